[design/rsa_pkg.sv]
// ----------------------------------------------------------------------------
// rsa_pkg: shared types and codes for the range set allocator
// Command, status and cell control codes used by the cell row and the core.
// ----------------------------------------------------------------------------
package rsa_pkg;

   localparam logic [1:0] CMD_ADD      = 2'd0;
   localparam logic [1:0] CMD_REMOVE   = 2'd1;
   localparam logic [1:0] CMD_POP_ONE  = 2'd2;
   localparam logic [1:0] CMD_POP_ALGN = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_PRECOND = 2'd2;
   localparam logic [1:0] ST_NO_FIT  = 2'd3;

   // cell row motion
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_ROTATE = 2'd1;  // every cell takes its upper neighbor
   localparam logic [1:0] CELL_OPEN   = 2'd2;  // cells above the index take lower neighbor
   localparam logic [1:0] CELL_CLOSE  = 2'd3;  // cells from the index up take upper neighbor

   // how an aligned block was found in an entry
   localparam logic [1:0] FIT_START = 2'd0;
   localparam logic [1:0] FIT_END   = 2'd1;
   localparam logic [1:0] FIT_SPLIT = 2'd2;

   localparam int ARG_W = 32;

   typedef struct packed {
      logic [1:0] mode;
      logic       a_start_en;
      logic       a_end_en;
      logic       b_start_en;
      logic       b_end_en;
   } cell_ctl_type;

endpackage

[design/rsa_cell.sv]
// ----------------------------------------------------------------------------
// rsa_cell: one entry of the range table
// Holds start and exclusive end, moves with the row and takes edits.
// ----------------------------------------------------------------------------
module rsa_cell #(
   parameter int SW   = 33,
   parameter int EW   = 32,
   parameter int IXW  = 6,
   parameter int SLOT = 0
) (
   input  logic                   clock,
   input  rsa_pkg::cell_ctl_type  ctl,
   input  logic [IXW-1:0]         shift_idx,
   input  logic [IXW-1:0]         a_idx,
   input  logic [SW-1:0]          a_start,
   input  logic [EW-1:0]          a_end,
   input  logic [IXW-1:0]         b_idx,
   input  logic [SW-1:0]          b_start,
   input  logic [EW-1:0]          b_end,
   input  logic [SW-1:0]          up_start,
   input  logic [EW-1:0]          up_end,
   input  logic [SW-1:0]          dn_start,
   input  logic [EW-1:0]          dn_end,
   output logic [SW-1:0]          start_q,
   output logic [EW-1:0]          end_q
);
   import rsa_pkg::*;

   localparam logic [IXW-1:0] MY_IDX = IXW'(SLOT);

   logic [SW-1:0] start_ff, start_in;
   logic [EW-1:0] end_ff, end_in;
   logic          hit_a, hit_b;

   assign hit_a = (a_idx == MY_IDX);
   assign hit_b = (b_idx == MY_IDX);

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      unique case (ctl.mode)
         CELL_ROTATE: begin
            start_in = up_start;
            end_in   = up_end;
         end
         CELL_OPEN: begin
            if (MY_IDX > shift_idx) begin
               start_in = dn_start;
               end_in   = dn_end;
            end
         end
         CELL_CLOSE: begin
            if (MY_IDX >= shift_idx) begin
               start_in = up_start;
               end_in   = up_end;
            end
         end
         default: begin
         end
      endcase
      if (ctl.a_start_en && hit_a) start_in = a_start;
      if (ctl.a_end_en && hit_a)   end_in   = a_end;
      if (ctl.b_start_en && hit_b) start_in = b_start;
      if (ctl.b_end_en && hit_b)   end_in   = b_end;
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
   end

   assign start_q = start_ff;
   assign end_q   = end_ff;

endmodule

[design/rsa_mod.sv]
// ----------------------------------------------------------------------------
// rsa_mod: bit-serial remainder unit
// Restoring division, one dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module rsa_mod #(
   parameter int DW = 33
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DW-1:0]                dividend,
   input  logic [rsa_pkg::ARG_W-1:0]    divisor,
   output logic                         done,
   output logic [rsa_pkg::ARG_W-1:0]    remainder
);
   import rsa_pkg::*;

   localparam int CNTW = $clog2(DW + 1);

   logic             busy_ff, done_ff;
   logic [CNTW-1:0]  cnt_ff;
   logic [DW-1:0]    dvd_ff;
   logic [ARG_W-1:0] rem_ff, rem_in;
   logic [ARG_W:0]   trial;

   always_comb begin
      trial = {rem_ff, dvd_ff[DW-1]};
      if (trial >= {1'b0, divisor}) trial = trial - {1'b0, divisor};
      rem_in = trial[ARG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNTW'(DW);
            dvd_ff  <= dividend;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= dvd_ff << 1;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNTW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[design/range_set_allocator_core.sv]
// ----------------------------------------------------------------------------
// range_set_allocator_core: sorted range table allocator
// Keeps a set of indices as disjoint ranges in a row of cells.
// ----------------------------------------------------------------------------
// Pop smallest and commands with bad arguments go from idle straight to the
// apply state. Add, remove and pop aligned rotate the whole cell row once,
// plus up to two remainder runs for every entry that pop aligned has to
// test. One command is in flight at a time. Reset clears the entry count,
// item count and control; entry contents are left as they are and are
// never read before written.
module range_set_allocator_core #(
   parameter int MAX_RANGES  = 64,
   parameter int INDEX_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // range_first, range_last, block_alignment, block_size
   input  logic [1:0]   req_tuser,   // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,   // popped_index, item_count, zero fill
   output logic [1:0]   rsp_tuser    // status
);
   import rsa_pkg::*;

   localparam int IW  = INDEX_WIDTH;
   localparam int SW  = IW + 1;
   localparam int CW  = IW + 1;
   localparam int MW  = (IW + 1 > ARG_W + 1) ? IW + 1 : ARG_W + 1;
   localparam int XW  = MW + 1;
   localparam int IXW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int UW  = $clog2(MAX_RANGES + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_DIV1  = 3'd2;
   localparam logic [2:0] S_DIV2  = 3'd3;
   localparam logic [2:0] S_APPLY = 3'd4;

   localparam logic [XW-1:0] SPACE  = XW'(1) << IW;
   localparam logic [IXW-1:0] LAST  = IXW'(MAX_RANGES - 1);
   localparam logic [UW-1:0]  FULL  = UW'(MAX_RANGES);

   // cell row
   logic [SW-1:0] cs [MAX_RANGES];
   logic [IW-1:0] ce [MAX_RANGES];
   cell_ctl_type  ctl;
   logic [IXW-1:0] shift_idx, a_idx, b_idx;
   logic [SW-1:0]  a_start, b_start;
   logic [IW-1:0]  a_end, b_end;

   for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
      rsa_cell #(.SW(SW), .EW(IW), .IXW(IXW), .SLOT(k)) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .shift_idx(shift_idx),
         .a_idx    (a_idx),
         .a_start  (a_start),
         .a_end    (a_end),
         .b_idx    (b_idx),
         .b_start  (b_start),
         .b_end    (b_end),
         .up_start (cs[(k + 1) % MAX_RANGES]),
         .up_end   (ce[(k + 1) % MAX_RANGES]),
         .dn_start (cs[(k + MAX_RANGES - 1) % MAX_RANGES]),
         .dn_end   (ce[(k + MAX_RANGES - 1) % MAX_RANGES]),
         .start_q  (cs[k]),
         .end_q    (ce[k])
      );
   end

   // remainder unit
   logic             div_start, div_done;
   logic [MW-1:0]    div_dvd;
   logic [ARG_W-1:0] div_rem;

   // control and captured command
   logic [2:0]       state_ff, state_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [IW-1:0]    f_ff, f_in, l_ff, l_in;
   logic [ARG_W-1:0] align_ff, align_in, size_ff, size_in;
   logic [IXW-1:0]   j_ff, j_in;
   logic [UW-1:0]    used_ff, used_in;
   logic [CW-1:0]    total_ff, total_in;
   logic             bad_ff, bad_in, hl_ff, hl_in, hr_ff, hr_in;
   logic [IXW-1:0]   left_ff, left_in, right_ff, right_in;
   logic [IW-1:0]    rend_ff, rend_in;
   logic [UW-1:0]    pos_ff, pos_in;
   logic             found_ff, found_in, skip_ff, skip_in;
   logic [IXW-1:0]   fidx_ff, fidx_in;
   logic [1:0]       fkind_ff, fkind_in;
   logic [XW-1:0]    fs_ff, fs_in, fe_ff, fe_in, fa_ff, fa_in;
   logic [IW-1:0]    fend_ff, fend_in;
   logic [ARG_W-1:0] srem_ff, srem_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_st_ff, rsp_st_in;
   logic [ARG_W-1:0] rsp_x_ff, rsp_x_in;
   logic [32:0]      rsp_cnt_ff, rsp_cnt_in;

   // head cell view and argument views
   logic [XW-1:0] hs, he, fx, lx, l1, szx, alx, av, ix, dx, x_v, tot_x, in_f, in_l;
   logic          vld, step, accept;
   logic [1:0]    st;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      hs  = XW'(cs[0]);
      he  = (ce[0] == '0) ? SPACE : XW'(ce[0]);
      fx  = XW'(f_ff);
      lx  = XW'(l_ff);
      l1  = lx + XW'(1);
      szx = XW'(size_ff);
      alx = XW'(align_ff);
      // next aligned boundary above the start, from the start's remainder
      av  = hs + alx - XW'(srem_ff);
      vld = ({1'b0, j_ff} < used_ff);
      in_f = XW'(req_tdata[31:0]);
      in_l = XW'(req_tdata[63:32]);
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff; f_in = f_ff; l_in = l_ff; align_in = align_ff; size_in = size_ff;
      j_in = j_ff; used_in = used_ff; total_in = total_ff;
      bad_in = bad_ff; hl_in = hl_ff; hr_in = hr_ff; left_in = left_ff; right_in = right_ff;
      rend_in = rend_ff; pos_in = pos_ff; found_in = found_ff; skip_in = skip_ff;
      fidx_in = fidx_ff; fkind_in = fkind_ff; fs_in = fs_ff; fe_in = fe_ff; fa_in = fa_ff;
      fend_in = fend_ff; srem_in = srem_ff;
      rsp_valid_in = rsp_valid_ff; rsp_st_in = rsp_st_ff; rsp_x_in = rsp_x_ff;
      rsp_cnt_in = rsp_cnt_ff;
      ctl = '{mode: CELL_HOLD, default: 1'b0};
      shift_idx = '0; a_idx = '0; b_idx = '0;
      a_start = '0; b_start = '0; a_end = '0; b_end = '0;
      div_start = 1'b0; div_dvd = '0;
      step = 1'b0; st = ST_OK; x_v = '0; ix = '0; dx = '0; tot_x = '0;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_tuser;
               f_in     = in_f[IW-1:0];
               l_in     = in_l[IW-1:0];
               align_in = req_tdata[95:64];
               size_in  = req_tdata[127:96];
               bad_in   = ((req_tuser == CMD_ADD || req_tuser == CMD_REMOVE) &&
                           (in_f[IW-1:0] > in_l[IW-1:0])) ||
                          (req_tuser == CMD_POP_ALGN &&
                           (req_tdata[95:64] == '0 || req_tdata[127:96] == '0));
               hl_in = 1'b0; hr_in = 1'b0; found_in = 1'b0; skip_in = 1'b0;
               pos_in = '0; j_in = '0;
               if (req_tuser == CMD_POP_ONE || bad_in) state_in = S_APPLY;
               else state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            step = 1'b1;
            if (vld) begin
               unique case (cmd_ff)
                  CMD_ADD: begin
                     if (fx < he && hs <= lx) bad_in = 1'b1;
                     if (he == fx) begin
                        hl_in = 1'b1; left_in = j_ff;
                     end
                     if (hs == l1) begin
                        hr_in = 1'b1; right_in = j_ff; rend_in = ce[0];
                     end
                     if (hs < fx) pos_in = UW'(j_ff) + UW'(1);
                  end
                  CMD_REMOVE: begin
                     if (!found_ff && hs <= fx && l1 <= he) begin
                        found_in = 1'b1; fidx_in = j_ff;
                        fs_in = hs; fe_in = he; fend_in = ce[0];
                     end
                  end
                  CMD_POP_ALGN: begin
                     if (!found_ff && (he - hs) >= szx) begin
                        step      = 1'b0;
                        div_start = 1'b1;
                        div_dvd   = hs[MW-1:0];
                        state_in  = S_DIV1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV1: begin
            if (div_done) begin
               srem_in = div_rem;
               if (div_rem == '0) begin
                  found_in = 1'b1; fkind_in = FIT_START; fidx_in = j_ff;
                  fs_in = hs; fe_in = he;
                  step = 1'b1;
               end else begin
                  dx        = he - szx;
                  div_start = 1'b1;
                  div_dvd   = dx[MW-1:0];
                  state_in  = S_DIV2;
               end
            end
         end
         S_DIV2: begin
            if (div_done) begin
               step = 1'b1;
               if (div_rem == '0) begin
                  found_in = 1'b1; fkind_in = FIT_END; fidx_in = j_ff;
                  fs_in = hs; fe_in = he;
               end else if (!(av > he || (he - av) < szx)) begin
                  if (used_ff >= FULL) begin
                     skip_in = 1'b1;
                  end else begin
                     found_in = 1'b1; fkind_in = FIT_SPLIT; fidx_in = j_ff;
                     fs_in = hs; fe_in = he; fa_in = av; fend_in = ce[0];
                  end
               end
            end
         end
         S_APPLY: begin
            unique case (cmd_ff)
               CMD_ADD: begin
                  if (bad_ff) begin
                     st = ST_PRECOND;
                  end else if (hl_ff && hr_ff) begin
                     ctl.a_end_en = 1'b1; a_idx = left_ff; a_end = rend_ff;
                     ctl.mode = CELL_CLOSE; shift_idx = right_ff;
                     used_in = used_ff - UW'(1);
                  end else if (hl_ff) begin
                     ctl.a_end_en = 1'b1; a_idx = left_ff; a_end = l1[IW-1:0];
                  end else if (hr_ff) begin
                     ctl.a_start_en = 1'b1; a_idx = right_ff; a_start = SW'(f_ff);
                  end else if (used_ff >= FULL) begin
                     st = ST_FULL;
                  end else begin
                     ctl.mode = CELL_OPEN; shift_idx = pos_ff[IXW-1:0];
                     ctl.a_start_en = 1'b1; ctl.a_end_en = 1'b1; a_idx = pos_ff[IXW-1:0];
                     a_start = SW'(f_ff); a_end = l1[IW-1:0];
                     used_in = used_ff + UW'(1);
                  end
                  tot_x = XW'(total_ff) + (l1 - fx);
               end
               CMD_REMOVE: begin
                  if (bad_ff || !found_ff) begin
                     st = ST_PRECOND;
                  end else if (fs_ff == fx) begin
                     if (l1 == fe_ff) begin
                        ctl.mode = CELL_CLOSE; shift_idx = fidx_ff;
                        used_in = used_ff - UW'(1);
                     end else begin
                        ctl.a_start_en = 1'b1; a_idx = fidx_ff; a_start = l1[SW-1:0];
                     end
                  end else if (fe_ff == l1) begin
                     ctl.a_end_en = 1'b1; a_idx = fidx_ff; a_end = f_ff;
                  end else if (used_ff >= FULL) begin
                     st = ST_FULL;
                  end else begin
                     ix = XW'(fidx_ff) + XW'(1);
                     ctl.mode = CELL_OPEN; shift_idx = ix[IXW-1:0];
                     ctl.b_start_en = 1'b1; ctl.b_end_en = 1'b1; b_idx = ix[IXW-1:0];
                     b_start = l1[SW-1:0]; b_end = fend_ff;
                     ctl.a_end_en = 1'b1; a_idx = fidx_ff; a_end = f_ff;
                     used_in = used_ff + UW'(1);
                  end
                  tot_x = XW'(total_ff) - (l1 - fx);
               end
               CMD_POP_ONE: begin
                  if (used_ff == '0) begin
                     st = ST_PRECOND;
                  end else begin
                     x_v = hs;
                     if (hs + XW'(1) == he) begin
                        ctl.mode = CELL_CLOSE; shift_idx = '0;
                        used_in = used_ff - UW'(1);
                     end else begin
                        ix = hs + XW'(1);
                        ctl.a_start_en = 1'b1; a_idx = '0; a_start = ix[SW-1:0];
                     end
                  end
                  tot_x = XW'(total_ff) - XW'(1);
               end
               default: begin
                  if (bad_ff) begin
                     st = ST_PRECOND;
                  end else if (!found_ff) begin
                     st = skip_ff ? ST_FULL : ST_NO_FIT;
                  end else begin
                     unique case (fkind_ff)
                        FIT_START: begin
                           x_v = fs_ff;
                           ix  = fs_ff + szx;
                           if (ix == fe_ff) begin
                              ctl.mode = CELL_CLOSE; shift_idx = fidx_ff;
                              used_in = used_ff - UW'(1);
                           end else begin
                              ctl.a_start_en = 1'b1; a_idx = fidx_ff; a_start = ix[SW-1:0];
                           end
                        end
                        FIT_END: begin
                           x_v = fe_ff - szx;
                           if (x_v == fs_ff) begin
                              ctl.mode = CELL_CLOSE; shift_idx = fidx_ff;
                              used_in = used_ff - UW'(1);
                           end else begin
                              ctl.a_end_en = 1'b1; a_idx = fidx_ff; a_end = x_v[IW-1:0];
                           end
                        end
                        default: begin
                           x_v = fa_ff;
                           ix  = XW'(fidx_ff) + XW'(1);
                           dx  = fa_ff + szx;
                           ctl.mode = CELL_OPEN; shift_idx = ix[IXW-1:0];
                           ctl.b_start_en = 1'b1; ctl.b_end_en = 1'b1; b_idx = ix[IXW-1:0];
                           b_start = dx[SW-1:0]; b_end = fend_ff;
                           ctl.a_end_en = 1'b1; a_idx = fidx_ff; a_end = fa_ff[IW-1:0];
                           used_in = used_ff + UW'(1);
                        end
                     endcase
                  end
                  tot_x = XW'(total_ff) - szx;
               end
            endcase
            if (st != ST_OK) begin
               x_v = '0;
               tot_x = XW'(total_ff);
               ctl = '{mode: CELL_HOLD, default: 1'b0};
               used_in = used_ff;
            end
            total_in     = tot_x[CW-1:0];
            rsp_valid_in = 1'b1;
            rsp_st_in    = st;
            rsp_x_in     = x_v[ARG_W-1:0];
            rsp_cnt_in   = 33'(tot_x[CW-1:0]);
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (step) begin
         ctl.mode = CELL_ROTATE;
         j_in = j_ff + IXW'(1);
         if (j_ff == LAST) begin
            j_in     = '0;
            state_in = S_APPLY;
         end else begin
            state_in = S_SCAN;
         end
      end
   end

   rsa_mod #(.DW(MW)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (align_ff),
      .done     (div_done),
      .remainder(div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         j_ff         <= j_in;
      end
      cmd_ff <= cmd_in; f_ff <= f_in; l_ff <= l_in; align_ff <= align_in; size_ff <= size_in;
      bad_ff <= bad_in; hl_ff <= hl_in; hr_ff <= hr_in; left_ff <= left_in;
      right_ff <= right_in; rend_ff <= rend_in; pos_ff <= pos_in;
      found_ff <= found_in; skip_ff <= skip_in; fidx_ff <= fidx_in; fkind_ff <= fkind_in;
      fs_ff <= fs_in; fe_ff <= fe_in; fa_ff <= fa_in; fend_ff <= fend_in;
      srem_ff <= srem_in;
      rsp_st_ff <= rsp_st_in; rsp_x_ff <= rsp_x_in; rsp_cnt_ff <= rsp_cnt_in;
   end

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_st_ff;
   assign rsp_tdata  = {7'd0, rsp_cnt_ff, rsp_x_ff};

endmodule

[design/rsa_checker.sv]
// ----------------------------------------------------------------------------
// rsa_checker: port-level checks for the range set allocator
// Watches the request and result channels of the core.
// ----------------------------------------------------------------------------
module rsa_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [71:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser
);
   import rsa_pkg::*;

   // a pending result beat is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped");

   // no new command while a result is pending
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request accepted with result pending");

   // a command is busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accept");

   // a nonzero popped index only comes with ok status
   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[31:0] != 32'd0 |-> rsp_tuser == ST_OK)
      else $error("popped index on failed command");

endmodule

bind range_set_allocator_core rsa_checker u_rsa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

[bench/range_set_allocator_core_test.sv]
// ----------------------------------------------------------------------------
// range_set_allocator_core_test: self-checking bench for the range allocator
// Drives add, remove and pop commands over the req stream and compares each
// rsp beat against a behavioral copy of the range table kept in a scoreboard.
// Directed corner cases first, then table-aware random traffic with and without stalls.
// ----------------------------------------------------------------------------
module range_set_allocator_core_test;
   import rsa_pkg::*;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] popped;
      logic [32:0] count;
   } alloc_resp_type;

   class range_table_model;
      bit [63:0]      rng_first[64];
      bit [63:0]      rng_end[64];     // exclusive, SPACE for top of index space
      int             used;
      bit [32:0]      count;
      alloc_resp_type pending[$];
      int             errors;
      int             status_seen[4];

      function void drop_entry(int i);
         for (int k = i; k + 1 < used; k++) begin
            rng_first[k] = rng_first[k + 1];
            rng_end[k]   = rng_end[k + 1];
         end
         used--;
      endfunction

      function void open_entry(int i);
         for (int k = used; k > i; k--) begin
            rng_first[k] = rng_first[k - 1];
            rng_end[k]   = rng_end[k - 1];
         end
         used++;
      endfunction

      function logic [1:0] add_range(bit [63:0] f, bit [63:0] l);
         int left, right, pos;
         bit has_l, has_r;
         left = 0; right = 0; pos = 0; has_l = 0; has_r = 0;
         if (f > l) return ST_PRECOND;
         for (int i = 0; i < used; i++) begin
            if (f < rng_end[i] && rng_first[i] <= l) return ST_PRECOND;
            if (rng_end[i] == f) begin has_l = 1; left = i; end
            if (rng_first[i] == l + 1) begin has_r = 1; right = i; end
            if (rng_first[i] < f) pos = i + 1;
         end
         if (has_l && has_r) begin
            rng_end[left] = rng_end[right];
            drop_entry(right);
         end else if (has_l) begin
            rng_end[left] = l + 1;
         end else if (has_r) begin
            rng_first[right] = f;
         end else begin
            if (used >= 64) return ST_FULL;
            open_entry(pos);
            rng_first[pos] = f;
            rng_end[pos]   = l + 1;
         end
         count = count + 33'(l - f + 1);
         return ST_OK;
      endfunction

      function logic [1:0] remove_range(bit [63:0] f, bit [63:0] l);
         if (f > l) return ST_PRECOND;
         for (int i = 0; i < used; i++) begin
            if (rng_first[i] <= f && l + 1 <= rng_end[i]) begin
               if (rng_first[i] == f) begin
                  if (l + 1 == rng_end[i]) drop_entry(i);
                  else rng_first[i] = l + 1;
               end else if (rng_end[i] == l + 1) begin
                  rng_end[i] = f;  // tail trim ends at the first removed index
               end else begin
                  if (used >= 64) return ST_FULL;
                  open_entry(i + 1);
                  rng_first[i + 1] = l + 1;
                  rng_end[i + 1]   = rng_end[i];
                  rng_end[i]       = f;
               end
               count = count - 33'(l - f + 1);
               return ST_OK;
            end
         end
         return ST_PRECOND;
      endfunction

      function logic [1:0] pop_one(output bit [63:0] x);
         x = 0;
         if (used == 0) return ST_PRECOND;
         x = rng_first[0];
         if (rng_first[0] + 1 == rng_end[0]) drop_entry(0);
         else rng_first[0] = rng_first[0] + 1;
         count = count - 1;
         return ST_OK;
      endfunction

      function logic [1:0] pop_aligned(bit [63:0] al, bit [63:0] sz, output bit [63:0] x);
         bit skipped;
         bit [63:0] s, e, a;
         skipped = 0; x = 0;
         if (al == 0 || sz == 0) return ST_PRECOND;
         for (int i = 0; i < used; i++) begin
            s = rng_first[i]; e = rng_end[i];
            if (e - s < sz) continue;
            if (s % al == 0) begin
               x = s;
               if (s + sz == e) drop_entry(i);
               else rng_first[i] = s + sz;
            end else if ((e - sz) % al == 0) begin
               x = e - sz;
               if (e - sz == s) drop_entry(i);
               else rng_end[i] = e - sz;
            end else begin
               a = s + al - (s % al);
               if (a > e || e - a < sz) continue;
               if (used >= 64) begin
                  skipped = 1;
                  continue;
               end
               open_entry(i + 1);
               rng_first[i + 1] = a + sz;
               rng_end[i + 1]   = rng_end[i];
               rng_end[i]       = a;
               x = a;
            end
            count = count - 33'(sz);
            return ST_OK;
         end
         return skipped ? ST_FULL : ST_NO_FIT;
      endfunction

      function void note_command(logic [1:0] cmd, bit [31:0] f, bit [31:0] l,
                                 bit [31:0] al, bit [31:0] sz);
         alloc_resp_type r;
         bit [63:0] x;
         x = 0;
         case (cmd)
            CMD_ADD:     r.status = add_range(f, l);
            CMD_REMOVE:  r.status = remove_range(f, l);
            CMD_POP_ONE: r.status = pop_one(x);
            default:     r.status = pop_aligned(al, sz, x);
         endcase
         r.popped = (r.status == ST_OK) ? x[31:0] : 32'd0;
         r.count  = count;
         pending.push_back(r);
      endfunction

      function void check_response(logic [1:0] st, logic [31:0] px, logic [32:0] cnt);
         alloc_resp_type r;
         if (pending.size() == 0) begin
            $error("unexpected rsp beat: status %0d popped %h count %h", st, px, cnt);
            errors++;
            return;
         end
         r = pending.pop_front();
         status_seen[r.status]++;
         if (st !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, st); errors++;
         end
         if (px !== r.popped) begin
            $error("popped_index: expected %h, got %h", r.popped, px); errors++;
         end
         if (cnt !== r.count) begin
            $error("item_count: expected %h, got %h", r.count, cnt); errors++;
         end
      endfunction
   endclass

   localparam bit [63:0] SPACE = 64'h1_0000_0000;
   localparam int STALL_LIMIT = 30000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;  // range_first, range_last, block_alignment, block_size
   logic [1:0]   req_tuser = '0;  // command
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [71:0]  rsp_tdata;       // popped_index, item_count, zero fill
   logic [1:0]   rsp_tuser;       // status

   range_table_model table_model = new;
   int tx_idle, rx_idle;
   int pressure_phase = 0;
   bit pressure_done  = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;
   int sent           = 0;

   range_set_allocator_core DUT (.*);

   always #5 clock = ~clock;

   // result side: random stalls plus one long hold-off during the second phase
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            table_model.check_response(rsp_tuser, rsp_tdata[31:0], rsp_tdata[64:32]);
         if (pressure_phase == 1 && !pressure_done) begin
            pressure_done = 1;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send(logic [1:0] cmd, bit [63:0] f, bit [63:0] l,
                       bit [63:0] al, bit [63:0] sz);
      req_tuser  <= cmd;
      req_tdata  <= {sz[31:0], al[31:0], l[31:0], f[31:0]};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      table_model.note_command(cmd, f[31:0], l[31:0], al[31:0], sz[31:0]);
      sent++;
      if ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic empty_table();
      while (table_model.used > 0)
         send(CMD_REMOVE, table_model.rng_first[0], table_model.rng_end[0] - 1, 1, 1);
   endtask

   task automatic random_command();
      int n, g, pick;
      bit [63:0] lo, hi, f, l, al, sz, room;
      n = table_model.used;
      pick = $urandom_range(99);
      if ($urandom_range(99) < 10) begin
         // unconstrained noise
         send(2'($urandom), $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 38) begin
         g  = $urandom_range(n);
         lo = (g == 0) ? 0 : table_model.rng_end[g - 1];
         hi = (g == n) ? SPACE : table_model.rng_first[g];
         if (hi <= lo) begin
            send(CMD_ADD, lo, lo, 1, 1);
         end else begin
            room = hi - lo;
            if ($urandom_range(9) == 0 && g == n) lo = hi - ((room < 64) ? room : 64);
            f = ($urandom_range(3) == 0) ? lo
                : lo + $urandom_range(((room < 48) ? room : 48) - 1);
            room = hi - f;
            l = ($urandom_range(3) == 0 && room <= 16) ? hi - 1
                : f + $urandom_range(((room < 16) ? room : 16) - 1);
            send(CMD_ADD, f, l, 1, 1);
         end
      end else if (pick < 62) begin
         if (n == 0) begin
            f = $urandom_range(300);
            send(CMD_REMOVE, f, f + $urandom_range(8), 1, 1);
         end else begin
            g = $urandom_range(n - 1);
            lo = table_model.rng_first[g];
            hi = table_model.rng_end[g];
            room = hi - lo;
            f = ($urandom_range(2) == 0) ? lo
                : lo + $urandom_range(((room < 32) ? room : 32) - 1);
            room = hi - f;
            l = ($urandom_range(3) == 0 && room <= 64) ? hi - 1
                : f + $urandom_range(((room < 8) ? room : 8) - 1);
            if ($urandom_range(9) == 0) l = l + 1 + $urandom_range(3);
            send(CMD_REMOVE, f, l, 1, 1);
         end
      end else if (pick < 78) begin
         send(CMD_POP_ONE, $urandom, $urandom, $urandom, $urandom);
      end else begin
         al = 64'd1 << $urandom_range(6);
         sz = $urandom_range(1, 12);
         if ($urandom_range(19) == 0) al = $urandom;
         if ($urandom_range(29) == 0) sz = $urandom;
         if ($urandom_range(39) == 0) al = 0;
         if ($urandom_range(39) == 0) sz = 0;
         send(CMD_POP_ALGN, $urandom, $urandom, al, sz);
      end
   endtask

   initial begin
      tx_idle = 24;
      rx_idle = 50;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty set, bad arguments
      send(CMD_POP_ONE, 0, 0, 1, 1);
      send(CMD_POP_ALGN, 0, 0, 1, 1);
      send(CMD_POP_ALGN, 0, 0, 4, 0);
      send(CMD_POP_ALGN, 0, 0, 0, 4);
      send(CMD_ADD, 20, 10, 1, 1);
      // whole index space, then carve it up
      send(CMD_ADD, 0, 32'hFFFF_FFFF, 1, 1);
      send(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 1, 1);
      send(CMD_REMOVE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1, 1);
      send(CMD_REMOVE, 100, 199, 1, 1);
      send(CMD_REMOVE, 0, 9, 1, 1);
      send(CMD_ADD, 50, 60, 1, 1);
      send(CMD_REMOVE, 150, 250, 1, 1);
      send(CMD_REMOVE, 40, 30, 1, 1);
      send(CMD_POP_ONE, 0, 0, 1, 1);
      send(CMD_POP_ALGN, 0, 0, 64, 16);
      send(CMD_POP_ALGN, 0, 0, 32'hFFFF_FFFF, 1);
      send(CMD_POP_ALGN, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(CMD_ADD, 100, 199, 1, 1);
      send(CMD_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1, 1);
      empty_table();
      // full table: every entry misaligned so an aligned pop must split
      for (int k = 0; k < 64; k++) send(CMD_ADD, 8 * k + 1, 8 * k + 6, 1, 1);
      send(CMD_ADD, 1000, 1000, 1, 1);
      send(CMD_REMOVE, 3, 3, 1, 1);
      send(CMD_POP_ALGN, 0, 0, 4, 1);
      send(CMD_POP_ALGN, 0, 0, 1, 6);
      empty_table();

      for (int ph = 0; ph < 3; ph++) begin
         tx_idle = (ph == 0) ? 24 : (ph == 1) ? 50 : 0;
         rx_idle = (ph == 0) ? 50 : (ph == 1) ? 24 : 0;
         pressure_phase = ph;
         for (int i = 0; i < 365; i++) random_command();
      end
      req_tvalid <= 1'b0;

      while (table_model.pending.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("%0d commands sent: %0d ok, %0d table full, %0d precondition, %0d no fit",
               sent, table_model.status_seen[ST_OK], table_model.status_seen[ST_FULL],
               table_model.status_seen[ST_PRECOND], table_model.status_seen[ST_NO_FIT]);
      $display("covered full-space ranges, splits, merges, full-table skips and stalls");
      if (table_model.errors == 0 && table_model.pending.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

[range_set_allocator_core.f]
design/rsa_pkg.sv
design/rsa_cell.sv
design/rsa_mod.sv
design/range_set_allocator_core.sv
design/rsa_checker.sv
bench/range_set_allocator_core_test.sv
